// ----- rtl/core/gdsd_pkg.sv -----
// ----------------------------------------------------------------------------
// gdsd_pkg
// types, constants and reciprocal factors shared by the date conversion
// pipeline
// ----------------------------------------------------------------------------
package gdsd_pkg;

    // field types
    typedef logic [13:0]        t_year;
    typedef logic [3:0]         t_month;
    typedef logic [4:0]         t_day;
    typedef logic signed [22:0] t_offset;
    typedef logic signed [22:0] t_diff;
    typedef logic [22:0]        t_jdn;

    // pipeline depths
    localparam int unsigned FWD_STAGES = 3;
    localparam int unsigned INV_STAGES = 9;

    // forward conversion constants
    localparam logic [14:0] EPOCH_YEAR  = 15'd4800;
    localparam logic [23:0] JDN_BIAS    = 24'd32045;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

    // valid window of day numbers, 0001-01-01 .. 9999-12-31
    localparam logic [23:0] JDN_FIRST   = 24'd1721426;
    localparam logic [23:0] JDN_LAST    = 24'd5373484;

    // saturation codes of the day difference
    localparam t_diff DIFF_MAX = 23'sh3FFFFF;
    localparam t_diff DIFF_MIN = 23'sh400000;

    // inverse conversion constants
    localparam logic [24:0] CENT_BIAS   = 25'd274277;
    localparam logic [22:0] CENT_OFS    = 23'd1363;   // 1401 - 38
    localparam logic [24:0] DAYS_4Y     = 25'd1461;
    localparam logic [10:0] MONTH_SPAN  = 11'd153;
    localparam logic [13:0] YEAR_BIAS   = 14'd4716;

    // reciprocal factors, floor(x * MUL >> SH) == x / divisor over the used range
    localparam int unsigned Y100_SH  = 22;
    localparam logic [15:0] Y100_MUL = 16'(((64'd1 << Y100_SH) + 64'd99) / 64'd100);
    localparam int unsigned CENT_SH  = 43;
    localparam logic [25:0] CENT_MUL = 26'(((64'd1 << CENT_SH) + 64'd146096) / 64'd146097);
    localparam int unsigned QUAD_SH  = 36;
    localparam logic [25:0] QUAD_MUL = 26'(((64'd1 << QUAD_SH) + 64'd1460) / 64'd1461);
    localparam int unsigned M153_SH  = 19;
    localparam logic [11:0] M153_MUL = 12'(((64'd1 << M153_SH) + 64'd152) / 64'd153);
    localparam int unsigned DIV5_SH  = 11;
    localparam logic [8:0]  DIV5_MUL = 9'(((64'd1 << DIV5_SH) + 64'd4) / 64'd5);

    // day numbers handed from the forward half to the inverse half
    typedef struct packed {
        t_jdn    base;
        t_jdn    other;
        t_offset off;
    } t_jdn_pair;

    // days before the start of shifted month m (march based), (153m + 2) / 5
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gdsd_fwd.sv -----
// ----------------------------------------------------------------------------
// gdsd_fwd
// three stage conversion of two gregorian dates to julian day numbers
// ----------------------------------------------------------------------------
module gdsd_fwd (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gdsd_pkg::t_year     i_base_year,
    input  gdsd_pkg::t_month    i_base_month,
    input  gdsd_pkg::t_day      i_base_day,
    input  gdsd_pkg::t_year     i_other_year,
    input  gdsd_pkg::t_month    i_other_month,
    input  gdsd_pkg::t_day      i_other_day,
    input  gdsd_pkg::t_offset   i_offset_days,
    output logic                o_valid,
    input  logic                i_stall,
    output gdsd_pkg::t_jdn_pair o_pair
);
    import gdsd_pkg::*;

    logic [FWD_STAGES-1:0] r_vld;
    logic [FWD_STAGES-1:0] en;

    t_year      yr    [2];
    t_month     mo    [2];
    t_day       dy    [2];
    logic       early [2];
    logic [3:0] mm    [2];
    logic [14:0] n_y     [2];
    logic [9:0]  n_small [2];
    logic [30:0] n_prod  [2];
    logic [8:0]  n_q100  [2];
    t_jdn        n_jdn   [2];

    logic [14:0] r_a_y     [2];
    logic [9:0]  r_a_small [2];
    t_offset     r_a_off;
    logic [14:0] r_b_y     [2];
    logic [9:0]  r_b_small [2];
    logic [8:0]  r_b_q100  [2];
    t_offset     r_b_off;
    t_jdn_pair   r_c_pair;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        en[FWD_STAGES-1] = !r_vld[FWD_STAGES-1] || !i_stall;
        for (int k = FWD_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_vld[FWD_STAGES-1];
    assign o_pair  = r_c_pair;

    always_comb begin
        yr[0] = i_base_year;  mo[0] = i_base_month;  dy[0] = i_base_day;
        yr[1] = i_other_year; mo[1] = i_other_month; dy[1] = i_other_day;
        for (int l = 0; l < 2; l++) begin
            // january and february count as months of the previous year
            early[l]   = (mo[l] <= 4'd2);
            mm[l]      = early[l] ? (mo[l] + 4'd9) : (mo[l] - 4'd3);
            n_y[l]     = 15'(yr[l]) + EPOCH_YEAR - 15'(early[l]);
            n_small[l] = 10'(dy[l]) + 10'(days_before(mm[l]));
            n_prod[l]  = 31'(r_a_y[l]) * 31'(Y100_MUL);
            n_q100[l]  = 9'(n_prod[l] >> Y100_SH);
            n_jdn[l]   = 23'(24'(r_b_y[l]) * 24'(DAYS_YEAR) + 24'(r_b_y[l] >> 2)
                       - 24'(r_b_q100[l]) + 24'(r_b_q100[l] >> 2)
                       + 24'(r_b_small[l]) - JDN_BIAS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < FWD_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_y     <= n_y;
            r_a_small <= n_small;
            r_a_off   <= i_offset_days;
        end
        if (en[1]) begin
            r_b_y     <= r_a_y;
            r_b_small <= r_a_small;
            r_b_q100  <= n_q100;
            r_b_off   <= r_a_off;
        end
        if (en[2]) begin
            r_c_pair.base  <= n_jdn[0];
            r_c_pair.other <= n_jdn[1];
            r_c_pair.off   <= r_b_off;
        end
    end

endmodule

// ----- rtl/core/gdsd_inv.sv -----
// ----------------------------------------------------------------------------
// gdsd_inv
// shift by offset, day difference and nine stage inverse to a gregorian date
// ----------------------------------------------------------------------------
module gdsd_inv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  gdsd_pkg::t_jdn_pair i_pair,
    output logic                o_valid,
    input  logic                i_stall,
    output gdsd_pkg::t_year     o_shifted_year,
    output gdsd_pkg::t_month    o_shifted_month,
    output gdsd_pkg::t_day      o_shifted_day,
    output gdsd_pkg::t_diff     o_days_between,
    output logic                o_out_of_range
);
    import gdsd_pkg::*;

    logic [INV_STAGES-1:0] r_vld;
    logic [INV_STAGES-1:0] en;

    // difference and range flag ride along every stage
    t_diff r_diff [INV_STAGES];
    logic  r_inr  [INV_STAGES];

    logic [24:0] n_j;
    logic [23:0] n_d24;
    t_diff       n_diff;
    logic        n_inr;
    logic [24:0] n_n1;
    logic [50:0] n_p1;
    t_jdn        n_f;
    logic [50:0] n_pe;
    logic [10:0] n_rem;
    logic [10:0] n_h;
    logic [22:0] n_p153;
    t_month      n_mo;
    t_year       n_yr;
    logic [7:0]  n_r;
    logic [16:0] n_p5;

    t_jdn        r_s0_j;
    t_jdn        r_s1_j;
    logic [7:0]  r_s1_q1;
    logic [24:0] r_s2_e;
    logic [24:0] r_s3_e;
    logic [13:0] r_s3_qe;
    logic [13:0] r_s4_qe;
    logic [10:0] r_s4_rem;
    logic [13:0] r_s5_qe;
    logic [10:0] r_s5_h;
    logic [13:0] r_s6_qe;
    logic [10:0] r_s6_h;
    logic [3:0]  r_s6_q153;
    t_year       r_s7_yr;
    t_month      r_s7_mo;
    logic [7:0]  r_s7_r;
    t_year       r_s8_yr;
    t_month      r_s8_mo;
    t_day        r_s8_dy;

    always_comb begin
        en[INV_STAGES-1] = !r_vld[INV_STAGES-1] || !i_stall;
        for (int k = INV_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall         = !en[0];
    assign o_valid         = r_vld[INV_STAGES-1];
    assign o_shifted_year  = r_s8_yr;
    assign o_shifted_month = r_s8_mo;
    assign o_shifted_day   = r_s8_dy;
    assign o_days_between  = r_diff[INV_STAGES-1];
    assign o_out_of_range  = !r_inr[INV_STAGES-1];

    always_comb begin
        // s0: shifted day number, range check, saturated difference
        n_j    = 25'(i_pair.base) + 25'(i_pair.off);
        n_inr  = !n_j[24] && (n_j[23:0] >= JDN_FIRST) && (n_j[23:0] <= JDN_LAST);
        n_d24  = 24'(i_pair.other) - 24'(i_pair.base);
        if (n_d24[23] != n_d24[22]) begin
            n_diff = n_d24[23] ? DIFF_MIN : DIFF_MAX;
        end else begin
            n_diff = t_diff'(n_d24[22:0]);
        end
        // s1: gregorian century count
        n_n1   = {r_s0_j, 2'b00} + CENT_BIAS;
        n_p1   = 51'(n_n1) * 51'(CENT_MUL);
        // s2: julian style day count
        n_f    = r_s1_j + CENT_OFS + 23'((10'(r_s1_q1) * 10'd3) >> 2);
        // s3: four year cycles
        n_pe   = 51'(r_s2_e) * 51'(QUAD_MUL);
        // s4: day within the four year cycle
        n_rem  = 11'(r_s3_e - 25'(r_s3_qe) * DAYS_4Y);
        // s5: month scaled position
        n_h    = 11'(11'(r_s4_rem >> 2) * 11'd5 + 11'd2);
        // s6: march based month
        n_p153 = 23'(r_s5_h) * 23'(M153_MUL);
        // s7: calendar month, year and day remainder
        n_mo   = (r_s6_q153 < 4'd10) ? (r_s6_q153 + 4'd3) : (r_s6_q153 - 4'd9);
        n_yr   = r_s6_qe - YEAR_BIAS + 14'(n_mo <= 4'd2);
        n_r    = 8'(r_s6_h - 11'(r_s6_q153) * MONTH_SPAN);
        // s8: day of month
        n_p5   = 17'(r_s7_r) * 17'(DIV5_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < INV_STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_diff[0] <= n_diff;
            r_inr[0]  <= n_inr;
            r_s0_j    <= n_j[22:0];
        end
        for (int k = 1; k < INV_STAGES; k++) begin
            if (en[k]) begin
                r_diff[k] <= r_diff[k-1];
                r_inr[k]  <= r_inr[k-1];
            end
        end
        if (en[1]) begin
            r_s1_j  <= r_s0_j;
            r_s1_q1 <= 8'(n_p1 >> CENT_SH);
        end
        if (en[2]) begin
            r_s2_e <= {n_f, 2'b11};
        end
        if (en[3]) begin
            r_s3_e  <= r_s2_e;
            r_s3_qe <= 14'(n_pe >> QUAD_SH);
        end
        if (en[4]) begin
            r_s4_qe  <= r_s3_qe;
            r_s4_rem <= n_rem;
        end
        if (en[5]) begin
            r_s5_qe <= r_s4_qe;
            r_s5_h  <= n_h;
        end
        if (en[6]) begin
            r_s6_qe   <= r_s5_qe;
            r_s6_h    <= r_s5_h;
            r_s6_q153 <= 4'(n_p153 >> M153_SH);
        end
        if (en[7]) begin
            r_s7_yr <= n_yr;
            r_s7_mo <= n_mo;
            r_s7_r  <= n_r;
        end
        if (en[8]) begin
            // date fields read zero when the shifted date is out of range
            r_s8_yr <= r_inr[7] ? r_s7_yr : '0;
            r_s8_mo <= r_inr[7] ? r_s7_mo : '0;
            r_s8_dy <= r_inr[7] ? (5'(n_p5 >> DIV5_SH) + 5'd1) : '0;
        end
    end

endmodule

// ----- rtl/core/gregorian_date_shift_and_difference_unit.sv -----
// ----------------------------------------------------------------------------
// gregorian_date_shift_and_difference_unit
// date shift by a signed day offset and day difference between two dates
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with a base date, a second date and a
//   signed day offset; a transaction is taken when i_valid is high and
//   o_stall is low
//   output channel: o_valid / i_stall with the shifted date, the day count
//   from base to second date (saturated to 23 bits) and an out of range flag
//   3 forward stages and 9 inverse stages lie between input and result;
//   throughput: one transaction per cycle while i_stall is low, set by the
//   single fully pipelined datapath
//   each stage holds its own valid bit, so a stalled receiver only freezes
//   full stages; bubbles fill up and input is still taken until the whole
//   pipe is full, then o_stall rises; nothing is lost or repeated
//   reset clears all valid bits; no clearing pass is needed
//   shifted date fields are zero when the result leaves years 1 to 9999
// ----------------------------------------------------------------------------
module gregorian_date_shift_and_difference_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input transaction
    input  logic                i_valid,
    output logic                o_stall,
    input  gdsd_pkg::t_year     i_base_year,
    input  gdsd_pkg::t_month    i_base_month,
    input  gdsd_pkg::t_day      i_base_day,
    input  gdsd_pkg::t_year     i_other_year,
    input  gdsd_pkg::t_month    i_other_month,
    input  gdsd_pkg::t_day      i_other_day,
    input  gdsd_pkg::t_offset   i_offset_days,
    // result transaction
    output logic                o_valid,
    input  logic                i_stall,
    output gdsd_pkg::t_year     o_shifted_year,
    output gdsd_pkg::t_month    o_shifted_month,
    output gdsd_pkg::t_day      o_shifted_day,
    output gdsd_pkg::t_diff     o_days_between,
    output logic                o_out_of_range
);
    import gdsd_pkg::*;

    // handoff between the forward and inverse halves
    logic      mid_valid;
    logic      mid_stall;
    t_jdn_pair mid_pair;

    // both dates to day numbers, offset carried along
    gdsd_fwd u_fwd (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_base_year   (i_base_year),
        .i_base_month  (i_base_month),
        .i_base_day    (i_base_day),
        .i_other_year  (i_other_year),
        .i_other_month (i_other_month),
        .i_other_day   (i_other_day),
        .i_offset_days (i_offset_days),
        .o_valid       (mid_valid),
        .i_stall       (mid_stall),
        .o_pair        (mid_pair)
    );

    // shift, difference and day number back to a calendar date
    gdsd_inv u_inv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (mid_valid),
        .o_stall         (mid_stall),
        .i_pair          (mid_pair),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_shifted_year  (o_shifted_year),
        .o_shifted_month (o_shifted_month),
        .o_shifted_day   (o_shifted_day),
        .o_days_between  (o_days_between),
        .o_out_of_range  (o_out_of_range)
    );

endmodule
